FILE: hdl/swsnd_pkg.sv
// Shared types and constants for the sliding-window sender.
package swsnd_pkg;

    localparam int OP_W  = 2;
    localparam int IDX_W = 8;
    localparam int SEQ_W = 5;
    localparam int WS_W  = 6;
    localparam int CNT_W = 9;
    localparam int CFG_W = 9;

    localparam int RESULT_LIMIT = 32;
    localparam int INDEX_LIMIT  = 256;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_NACK    = 2'd2;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd3;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam int MARK_ACKED = 0;
    localparam int MARK_SENT  = 1;
    localparam int MARK_W     = 2;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic ack_write;
        logic check_init;
        logic check_run;
        logic advance;
        logic complete;
        logic mod_init;
        logic mod_run;
        logic send_init;
        logic send_run;
        logic flush;
    } swsnd_cmd_t;

    typedef struct packed {
        logic            finished;
        logic            in_range;
        logic [OP_W-1:0] op;
        logic            is_base;
        logic            hit_acked;
        logic            in_window;
        logic            scan_done;
        logic            all_acked;
        logic            mod_done;
    } swsnd_status_t;

endpackage

FILE: hdl/swsnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swsnd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/swsnd_ctrl.sv
// Controller state machine for the sliding-window sender.
module swsnd_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [swsnd_pkg::OP_W-1:0]     op,
    input  swsnd_pkg::swsnd_status_t       status,
    output swsnd_pkg::swsnd_cmd_t          cmd,
    output logic                           busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOKUP = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_PREP   = 7'b0010000,
        S_MOD    = 7'b0100000,
        S_SEND   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (!status.finished)
                    begin
                        case (op)
                            swsnd_pkg::OP_START:
                            begin
                                state_next = S_PREP;
                            end
                            swsnd_pkg::OP_ACK, swsnd_pkg::OP_TIMEOUT:
                            begin
                                if (status.in_range)
                                begin
                                    state_next = S_LOOKUP;
                                end
                            end
                            swsnd_pkg::OP_NACK:
                            begin
                                state_next = S_IDLE;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.op == swsnd_pkg::OP_ACK)
                begin
                    cmd.ack_write = 1'b1;
                    if (status.is_base)
                    begin
                        cmd.check_init = 1'b1;
                        state_next     = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (!status.hit_acked && status.in_window)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                cmd.check_run = 1'b1;
                if (status.scan_done)
                begin
                    if (status.all_acked)
                    begin
                        cmd.complete = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                cmd.mod_init = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                if (status.mod_done)
                begin
                    cmd.send_init = 1'b1;
                    state_next    = S_SEND;
                end
                else
                begin
                    cmd.mod_run = 1'b1;
                end
            end
            S_SEND:
            begin
                cmd.send_run = 1'b1;
                if (status.scan_done)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hdl/swsnd_datapath.sv
// Datapath of the sliding-window sender: marks memory, window scan and result register.
module swsnd_datapath #(
    parameter int DEPTH   = 256,
    parameter int WIN_MAX = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [swsnd_pkg::CFG_W-1:0]     cfg_data,
    input  logic [swsnd_pkg::OP_W-1:0]      op,
    input  logic [swsnd_pkg::IDX_W-1:0]     entry_index,
    input  swsnd_pkg::swsnd_cmd_t           cmd,
    output swsnd_pkg::swsnd_status_t        status,
    output logic                            result_strobe,
    output logic                            kind,
    output logic [swsnd_pkg::IDX_W-1:0]     frame_index,
    output logic [swsnd_pkg::SEQ_W-1:0]     seq_num,
    output logic                            last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((IW > swsnd_pkg::WS_W) ? IW : swsnd_pkg::WS_W) + 1;

    logic [swsnd_pkg::WS_W-1:0]  window_size_reg;
    logic [swsnd_pkg::CNT_W-1:0] message_count_reg;
    logic [swsnd_pkg::OP_W-1:0]  op_reg;
    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               base_reg;
    logic                        finished_reg;
    logic [SW-1:0]               ptr_reg;
    logic [swsnd_pkg::SEQ_W-1:0] seq_reg;
    logic                        rd_vld_reg;
    logic [IW-1:0]               chk_idx_reg;
    logic [swsnd_pkg::SEQ_W-1:0] chk_seq_reg;
    logic                        fail_reg;
    logic [swsnd_pkg::SEQ_W-1:0] rem_reg;
    logic [IW-1:0]               mod_sh_reg;
    logic [CW-1:0]               mod_cnt_reg;
    logic                        pend_vld_reg;
    logic [IW-1:0]               pend_idx_reg;
    logic [swsnd_pkg::SEQ_W-1:0] pend_seq_reg;
    logic                        strobe_reg;
    logic                        kind_reg;
    logic [swsnd_pkg::IDX_W-1:0] frame_reg;
    logic [swsnd_pkg::SEQ_W-1:0] seq_out_reg;
    logic                        last_reg;
    logic [DEPTH-1:0]            valid_reg;
    logic                        valid_q_reg;

    logic [swsnd_pkg::WS_W-1:0]   ws_eff;
    logic [CW-1:0]                cnt_eff;
    logic [SW-1:0]                base_ext;
    logic [SW-1:0]                cnt_ext;
    logic [SW-1:0]                idx_ext;
    logic [SW-1:0]                base_plus;
    logic [SW-1:0]                win_end;
    logic [SW-1:0]                scan_end;
    logic [SW-1:0]                idx_p1;
    logic [SW-1:0]                cnt_m1;
    logic                         scanning;
    logic                         issue;
    logic                         push;
    logic                         out_fire;
    logic [swsnd_pkg::MARK_W-1:0] ram_rdata;
    logic [swsnd_pkg::MARK_W-1:0] rd_mark;
    logic [swsnd_pkg::MARK_W-1:0] ram_wdata;
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [IW-1:0]                ram_raddr;
    logic [swsnd_pkg::SEQ_W-1:0]  seq_inc;
    logic [swsnd_pkg::WS_W-1:0]   mod_t;
    logic [swsnd_pkg::WS_W-1:0]   mod_diff;
    logic [swsnd_pkg::SEQ_W-1:0]  rem_step;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            ws_eff = swsnd_pkg::WS_W'(1);
        end
        else if (window_size_reg > swsnd_pkg::WS_W'(WIN_MAX))
        begin
            ws_eff = swsnd_pkg::WS_W'(WIN_MAX);
        end
        else
        begin
            ws_eff = window_size_reg;
        end

        if (message_count_reg == '0)
        begin
            cnt_eff = CW'(1);
        end
        else if (message_count_reg > swsnd_pkg::CNT_W'(DEPTH))
        begin
            cnt_eff = CW'(DEPTH);
        end
        else
        begin
            cnt_eff = CW'(message_count_reg);
        end
    end

    assign base_ext  = SW'(base_reg);
    assign cnt_ext   = SW'(cnt_eff);
    assign idx_ext   = SW'(idx_reg);
    assign base_plus = base_ext + SW'(ws_eff);
    assign win_end   = (base_plus < cnt_ext) ? base_plus : cnt_ext;
    assign scan_end  = cmd.check_run ? cnt_ext : win_end;
    assign idx_p1    = idx_ext + SW'(1);
    assign cnt_m1    = cnt_ext - SW'(1);

    assign rd_mark  = valid_q_reg ? ram_rdata : '0;
    assign scanning = cmd.check_run || cmd.send_run;
    assign issue    = scanning && (ptr_reg < scan_end) && !(cmd.check_run && fail_reg);
    assign push     = cmd.send_run && rd_vld_reg
                      && ((op_reg == swsnd_pkg::OP_TIMEOUT) || !rd_mark[swsnd_pkg::MARK_SENT]);
    assign out_fire = ((push || cmd.flush) && pend_vld_reg) || cmd.complete;

    assign seq_inc = ((swsnd_pkg::WS_W'(seq_reg) + swsnd_pkg::WS_W'(1)) == ws_eff)
                     ? '0 : seq_reg + swsnd_pkg::SEQ_W'(1);

    assign mod_t    = {rem_reg, mod_sh_reg[IW-1]};
    assign mod_diff = mod_t - ws_eff;
    assign rem_step = (mod_t >= ws_eff) ? swsnd_pkg::SEQ_W'(mod_diff)
                                        : swsnd_pkg::SEQ_W'(mod_t);

    always_comb
    begin
        ram_we    = cmd.ack_write || push;
        ram_waddr = cmd.ack_write ? idx_reg : chk_idx_reg;
        ram_wdata = '0;
        if (cmd.ack_write)
        begin
            ram_wdata[swsnd_pkg::MARK_SENT]  = rd_mark[swsnd_pkg::MARK_SENT];
            ram_wdata[swsnd_pkg::MARK_ACKED] = 1'b1;
        end
        else
        begin
            ram_wdata[swsnd_pkg::MARK_SENT]  = 1'b1;
            ram_wdata[swsnd_pkg::MARK_ACKED] = 1'b0;
        end
        ram_raddr = cmd.lookup ? idx_reg : ptr_reg[IW-1:0];
    end

    swsnd_ram #(
        .WIDTH (swsnd_pkg::MARK_W),
        .DEPTH (DEPTH)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.finished  = finished_reg;
        status.in_range  = swsnd_pkg::CNT_W'(entry_index) < swsnd_pkg::CNT_W'(cnt_eff);
        status.op        = op_reg;
        status.is_base   = (idx_reg == base_reg);
        status.hit_acked = rd_mark[swsnd_pkg::MARK_ACKED];
        status.in_window = (idx_ext >= base_ext) && (idx_ext < base_plus);
        status.scan_done = !issue && !rd_vld_reg;
        status.all_acked = !fail_reg;
        status.mod_done  = (mod_cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= swsnd_pkg::WS_W'(4);
            message_count_reg <= swsnd_pkg::CNT_W'(1);
            base_reg          <= '0;
            finished_reg      <= 1'b0;
            rd_vld_reg        <= 1'b0;
            fail_reg          <= 1'b0;
            mod_cnt_reg       <= '0;
            pend_vld_reg      <= 1'b0;
            strobe_reg        <= 1'b0;
            valid_reg         <= '0;
            valid_q_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == swsnd_pkg::CFG_WINDOW)
                begin
                    window_size_reg <= cfg_data[swsnd_pkg::WS_W-1:0];
                end
                else if (cfg_index == swsnd_pkg::CFG_COUNT)
                begin
                    message_count_reg <= cfg_data[swsnd_pkg::CNT_W-1:0];
                end
            end

            if (cmd.advance)
            begin
                base_reg <= (idx_p1 < cnt_ext) ? IW'(idx_p1) : IW'(cnt_m1);
            end

            if (cmd.complete)
            begin
                finished_reg <= 1'b1;
            end

            if (cmd.check_init || cmd.send_init)
            begin
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= issue;
            end

            if (cmd.check_init)
            begin
                fail_reg <= 1'b0;
            end
            else if (cmd.check_run && rd_vld_reg && !rd_mark[swsnd_pkg::MARK_ACKED])
            begin
                fail_reg <= 1'b1;
            end

            if (cmd.mod_init)
            begin
                mod_cnt_reg <= CW'(IW);
            end
            else if (cmd.mod_run)
            begin
                mod_cnt_reg <= mod_cnt_reg - CW'(1);
            end

            if (push)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_vld_reg <= 1'b0;
            end

            strobe_reg <= out_fire;

            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            idx_reg <= entry_index[IW-1:0];
        end

        if (cmd.check_init)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.send_init)
        begin
            ptr_reg <= base_ext;
            seq_reg <= rem_reg;
        end
        else if (issue)
        begin
            ptr_reg     <= ptr_reg + SW'(1);
            seq_reg     <= seq_inc;
            chk_idx_reg <= ptr_reg[IW-1:0];
            chk_seq_reg <= seq_reg;
        end

        if (cmd.mod_init)
        begin
            rem_reg    <= '0;
            mod_sh_reg <= base_reg;
        end
        else if (cmd.mod_run)
        begin
            rem_reg    <= rem_step;
            mod_sh_reg <= mod_sh_reg << 1;
        end

        if (push)
        begin
            pend_idx_reg <= chk_idx_reg;
            pend_seq_reg <= chk_seq_reg;
        end

        if (cmd.complete)
        begin
            kind_reg    <= swsnd_pkg::KIND_DONE;
            frame_reg   <= '0;
            seq_out_reg <= '0;
            last_reg    <= 1'b1;
        end
        else
        begin
            kind_reg    <= swsnd_pkg::KIND_SEND;
            frame_reg   <= swsnd_pkg::IDX_W'(pend_idx_reg);
            seq_out_reg <= pend_seq_reg;
            last_reg    <= cmd.flush;
        end
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign frame_index   = frame_reg;
    assign seq_num       = seq_out_reg;
    assign last          = last_reg;

`ifndef SYNTH
    // A new item never finds a frame still held back from the previous one.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.capture |-> !pend_vld_reg)
        else $error("pending frame left over at item capture");

    // Completion is reported in the same cycle as the finished flag rises.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(finished_reg) |-> (strobe_reg && kind_reg == swsnd_pkg::KIND_DONE && last_reg))
        else $error("finished set without a completion result");

    // Frames are only ever sent from inside the current window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.send_run && rd_vld_reg) |-> (SW'(chk_idx_reg) < win_end))
        else $error("frame outside the window");

    // Once finished, the marks are never touched again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && $past(finished_reg)) |-> !ram_we)
        else $error("marks written after completion");
`endif

endmodule

FILE: hdl/sliding_window_sender.sv
// Top level of the sliding-window sender: controller and datapath.
//
// One item is handled at a time; busy is high while it is worked on and a new
// item is taken when start is high and busy is low. A negative acknowledgement,
// an item after completion, or an acknowledgement or timeout with an index beyond
// the message count is finished without busy rising and gives no result; an
// acknowledgement of a non-base entry, or a timeout that does not trigger a
// resend, passes through a lookup and a decide state with no result. A start, an
// accepted timeout, or an acknowledgement that moves the base first works out the
// base modulo the window size in a bit-serial remainder unit and then scans the
// window through the single read port of the marks memory at one entry a cycle;
// an acknowledgement of the base additionally scans the acked marks from entry
// zero up to the message count. Results come out one a cycle at most, each on
// the result ports for exactly one cycle with result_strobe high. A frame is held
// back until the next frame to send or the end of the scan is found, so that the
// last of an item can be marked by last, and that last result shows in the cycle
// in which busy falls; the receiver must take every result when it is shown.
// Configuration must be written only while busy is low; the block itself does not
// enforce this. Marks need no clearing pass after reset.
module sliding_window_sender #(
    parameter int MAX_MESSAGES = 256,
    parameter int MAX_WINDOW   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [swsnd_pkg::OP_W-1:0]      op,
    input  logic [swsnd_pkg::IDX_W-1:0]     entry_index,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [swsnd_pkg::CFG_W-1:0]     cfg_data,
    output logic                            result_strobe,
    output logic                            kind,
    output logic [swsnd_pkg::IDX_W-1:0]     frame_index,
    output logic [swsnd_pkg::SEQ_W-1:0]     seq_num,
    output logic                            last
);

    localparam int DEPTH = (MAX_MESSAGES < swsnd_pkg::INDEX_LIMIT)
                           ? MAX_MESSAGES : swsnd_pkg::INDEX_LIMIT;
    localparam int WIN_MAX = (MAX_WINDOW < swsnd_pkg::RESULT_LIMIT)
                             ? MAX_WINDOW : swsnd_pkg::RESULT_LIMIT;

    swsnd_pkg::swsnd_cmd_t    cmd;
    swsnd_pkg::swsnd_status_t status;

    swsnd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    swsnd_datapath #(
        .DEPTH   (DEPTH),
        .WIN_MAX (WIN_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (op),
        .entry_index   (entry_index),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .kind          (kind),
        .frame_index   (frame_index),
        .seq_num       (seq_num),
        .last          (last)
    );

endmodule

FILE: tb/sliding_window_sender_test.sv
// Self-checking testbench for the sliding-window sender, predicting every frame it emits.
module sliding_window_sender_test;

    localparam int MSG_DEPTH      = 256;
    localparam int WIN_DEPTH      = 32;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic                        kind;
        logic [swsnd_pkg::IDX_W-1:0] frame;
        logic [swsnd_pkg::SEQ_W-1:0] seq;
        logic                        last;
    } frame_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [swsnd_pkg::OP_W-1:0]  op = swsnd_pkg::OP_START;
    logic [swsnd_pkg::IDX_W-1:0] entry_index = '0;
    logic                        cfg_we = 1'b0;
    logic                        cfg_index = swsnd_pkg::CFG_WINDOW;
    logic [swsnd_pkg::CFG_W-1:0] cfg_data = '0;
    logic                        busy;
    logic                        result_strobe;
    logic                        kind;
    logic [swsnd_pkg::IDX_W-1:0] frame_index;
    logic [swsnd_pkg::SEQ_W-1:0] seq_num;
    logic                        last;

    bit [MSG_DEPTH-1:0]          acked_map = '0;
    bit [MSG_DEPTH-1:0]          sent_map = '0;
    int                          win_base = 0;
    bit                          all_delivered = 1'b0;
    logic [swsnd_pkg::WS_W-1:0]  window_reg = 6'd4;
    logic [swsnd_pkg::CNT_W-1:0] count_reg = 9'd1;

    frame_t      expected_frames[$];
    frame_t      want;
    frame_t      got;
    int unsigned gap_pct = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    sliding_window_sender #(
        .MAX_MESSAGES (MSG_DEPTH),
        .MAX_WINDOW   (WIN_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .entry_index   (entry_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .kind          (kind),
        .frame_index   (frame_index),
        .seq_num       (seq_num),
        .last          (last)
    );

    always #5 clk = ~clk;

    function automatic int window_span();
        int w;
        w = int'(window_reg);
        if (w < 1) w = 1;
        if (w > WIN_DEPTH) w = WIN_DEPTH;
        if (w > swsnd_pkg::RESULT_LIMIT) w = swsnd_pkg::RESULT_LIMIT;
        return w;
    endfunction

    function automatic int message_total();
        int c;
        c = int'(count_reg);
        if (c < 1) c = 1;
        if (c > MSG_DEPTH) c = MSG_DEPTH;
        if (c > swsnd_pkg::INDEX_LIMIT) c = swsnd_pkg::INDEX_LIMIT;
        return c;
    endfunction

    function automatic void queue_window_frames(bit resend);
        frame_t batch[$];
        frame_t f;
        int     ws;
        int     stop;
        int     i;
        ws = window_span();
        stop = win_base + ws;
        if (stop > message_total()) stop = message_total();
        for (i = win_base; i < stop && batch.size() < swsnd_pkg::RESULT_LIMIT; i++)
        begin
            if (resend || !sent_map[i])
            begin
                sent_map[i] = 1'b1;
                acked_map[i] = 1'b0;
                f.kind = swsnd_pkg::KIND_SEND;
                f.frame = swsnd_pkg::IDX_W'(i);
                f.seq = swsnd_pkg::SEQ_W'(i % ws);
                f.last = 1'b0;
                batch = {batch, f};
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        expected_frames = {expected_frames, batch};
    endfunction

    // Returns whether the item changes anything or can produce a frame.
    function automatic bit predict_frames(logic [swsnd_pkg::OP_W-1:0] o,
                                          logic [swsnd_pkg::IDX_W-1:0] idx);
        int     cnt;
        int     nb;
        int     i;
        bit     every_acked;
        frame_t f;
        cnt = message_total();
        if (all_delivered) return 1'b0;
        case (o)
            swsnd_pkg::OP_START:
                queue_window_frames(1'b0);
            swsnd_pkg::OP_ACK:
            begin
                if (idx >= cnt) return 1'b0;
                acked_map[idx] = 1'b1;
                if (idx != win_base) return 1'b1;
                every_acked = 1'b1;
                for (i = 0; i < cnt; i++)
                    if (!acked_map[i]) every_acked = 1'b0;
                if (every_acked)
                begin
                    all_delivered = 1'b1;
                    f.kind = swsnd_pkg::KIND_DONE;
                    f.frame = '0;
                    f.seq = '0;
                    f.last = 1'b1;
                    expected_frames = {expected_frames, f};
                    return 1'b1;
                end
                nb = int'(idx) + 1;
                if (nb > cnt - 1) nb = cnt - 1;
                win_base = nb;
                queue_window_frames(1'b0);
            end
            swsnd_pkg::OP_TIMEOUT:
            begin
                if (idx >= cnt) return 1'b0;
                if (!acked_map[idx] && idx >= win_base && idx < win_base + window_span())
                    queue_window_frames(1'b1);
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic bit would_complete(logic [swsnd_pkg::OP_W-1:0] o,
                                          logic [swsnd_pkg::IDX_W-1:0] idx);
        int cnt;
        int i;
        cnt = message_total();
        if (all_delivered || o != swsnd_pkg::OP_ACK || idx >= cnt || idx != win_base)
            return 1'b0;
        for (i = 0; i < cnt; i++)
            if (i != idx && !acked_map[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(input logic [swsnd_pkg::OP_W-1:0] o,
                             input logic [swsnd_pkg::IDX_W-1:0] idx,
                             output bit effective);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        start <= 1'b1;
        op <= o;
        entry_index <= idx;
        do @(posedge clk); while (busy);
        effective = predict_frames(o, idx);
    endtask

    task automatic send(input logic [swsnd_pkg::OP_W-1:0] o,
                        input logic [swsnd_pkg::IDX_W-1:0] idx);
        bit effective;
        send_item(o, idx, effective);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [swsnd_pkg::CFG_W-1:0] window,
                             input logic [swsnd_pkg::CFG_W-1:0] count);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= swsnd_pkg::CFG_WINDOW;
        cfg_data <= window;
        @(posedge clk);
        window_reg = window[swsnd_pkg::WS_W-1:0];
        cfg_index <= swsnd_pkg::CFG_COUNT;
        cfg_data <= count;
        @(posedge clk);
        count_reg = count[swsnd_pkg::CNT_W-1:0];
        cfg_we <= 1'b0;
    endtask

    task automatic check_reset_defaults();
        gap_pct = 0;
        send(swsnd_pkg::OP_START, 8'd0);
        send(swsnd_pkg::OP_NACK, 8'd0);
        send(swsnd_pkg::OP_ACK, 8'd5);
        send(swsnd_pkg::OP_TIMEOUT, 8'd0);
        send(swsnd_pkg::OP_TIMEOUT, 8'd255);
    endtask

    task automatic check_wide_window();
        configure(9'd63, 9'd511);
        send(swsnd_pkg::OP_START, 8'd0);
        send(swsnd_pkg::OP_TIMEOUT, 8'd5);
        send(swsnd_pkg::OP_ACK, 8'd31);
        send(swsnd_pkg::OP_ACK, 8'd0);
        send(swsnd_pkg::OP_ACK, 8'd255);
        send(swsnd_pkg::OP_TIMEOUT, 8'd255);
        send(swsnd_pkg::OP_TIMEOUT, 8'd0);
        send(swsnd_pkg::OP_NACK, 8'd170);
    endtask

    task automatic check_base_beyond_count();
        configure(9'd0, 9'd0);
        send(swsnd_pkg::OP_START, 8'd0);
        send(swsnd_pkg::OP_ACK, 8'd0);
        send(swsnd_pkg::OP_TIMEOUT, 8'd0);
    endtask

    task automatic check_narrow_window();
        configure(9'd1, 9'd256);
        send(swsnd_pkg::OP_START, 8'd0);
        send(swsnd_pkg::OP_TIMEOUT, swsnd_pkg::IDX_W'(win_base));
        send(swsnd_pkg::OP_ACK, swsnd_pkg::IDX_W'(win_base));
    endtask

    task automatic check_random_traffic(input int unsigned items, input int unsigned gap,
                                        input logic [swsnd_pkg::CFG_W-1:0] window,
                                        input logic [swsnd_pkg::CFG_W-1:0] count);
        int unsigned                 handled;
        int unsigned                 pick;
        logic [swsnd_pkg::OP_W-1:0]  o;
        logic [swsnd_pkg::IDX_W-1:0] idx;
        bit                          effective;
        configure(window, count);
        gap_pct = gap;
        handled = 0;
        while (handled < items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                o = swsnd_pkg::OP_START;
                idx = swsnd_pkg::IDX_W'($urandom);
            end
            else if (pick < 40)
            begin
                o = swsnd_pkg::OP_ACK;
                idx = swsnd_pkg::IDX_W'(win_base);
            end
            else if (pick < 58)
            begin
                o = swsnd_pkg::OP_ACK;
                idx = swsnd_pkg::IDX_W'(win_base + int'($urandom_range(window_span() - 1)));
            end
            else if (pick < 73)
            begin
                o = swsnd_pkg::OP_TIMEOUT;
                idx = swsnd_pkg::IDX_W'(win_base + int'($urandom_range(window_span() - 1)));
            end
            else if (pick < 80)
            begin
                o = swsnd_pkg::OP_NACK;
                idx = swsnd_pkg::IDX_W'($urandom);
            end
            else
            begin
                o = swsnd_pkg::OP_W'($urandom);
                idx = swsnd_pkg::IDX_W'($urandom);
            end
            // Completion is kept back for the final test, since it cannot be undone.
            if (would_complete(o, idx)) o = swsnd_pkg::OP_NACK;
            if ($urandom_range(99) == 0)
            begin
                start <= 1'b0;
                do @(posedge clk); while (expected_frames.size() != 0);
            end
            send_item(o, idx, effective);
            if (effective) handled++;
        end
    endtask

    task automatic check_completion();
        configure(swsnd_pkg::CFG_W'($urandom_range(1, 63)), swsnd_pkg::CFG_W'(win_base + 1));
        gap_pct = 0;
        send(swsnd_pkg::OP_ACK, swsnd_pkg::IDX_W'(win_base));
        send(swsnd_pkg::OP_START, 8'd0);
        send(swsnd_pkg::OP_TIMEOUT, swsnd_pkg::IDX_W'(win_base));
        send(swsnd_pkg::OP_ACK, 8'd0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            got = '{kind: kind, frame: frame_index, seq: seq_num, last: last};
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected frame: kind=%0d index=%0d seq=%0d last=%0d",
                         $time, kind, frame_index, seq_num, last);
                mismatch_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got !== want)
                begin
                    $display("%0t: kind/index/seq/last expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $time, want.kind, want.frame, want.seq, want.last,
                             kind, frame_index, seq_num, last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reset_defaults();
        check_wide_window();
        check_base_beyond_count();
        check_narrow_window();
        check_random_traffic(165, 29, swsnd_pkg::CFG_W'($urandom_range(2, 8)), 9'd256);
        check_random_traffic(165, 53, swsnd_pkg::CFG_W'($urandom_range(9, 63)),
                             swsnd_pkg::CFG_W'($urandom_range(257, 511)));
        check_random_traffic(170, 0, swsnd_pkg::CFG_W'($urandom_range(1, 32)), 9'd256);
        check_completion();
        wait_idle();
        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sliding_window_sender.f
hdl/swsnd_pkg.sv
hdl/swsnd_ram.sv
hdl/swsnd_ctrl.sv
hdl/swsnd_datapath.sv
hdl/sliding_window_sender.sv
tb/sliding_window_sender_test.sv
